/* hw/rtl/ibd_pkg.sv */
// shared types, opcode constants and length table for the instruction boundary decoder
`timescale 1ns / 1ps

package ibd_pkg;

  localparam logic [15:0] ORIGIN_RESET = 16'h2000;

  localparam logic [7:0] OP_REP = 8'hC2;
  localparam logic [7:0] OP_SEP = 8'hE2;

  localparam int MFLAG_BIT = 5;
  localparam int XFLAG_BIT = 4;

  typedef enum logic [3:0] {
    MODE_IMPLIED  = 4'd0,
    MODE_IMM      = 4'd1,
    MODE_REL      = 4'd2,
    MODE_REL_LONG = 4'd3,
    MODE_DP       = 4'd4,
    MODE_DP_X     = 4'd5,
    MODE_ABS      = 4'd6,
    MODE_ABS_X    = 4'd7,
    MODE_ABS_Y    = 4'd8,
    MODE_DP_IND   = 4'd9,
    MODE_DP_LONG  = 4'd10,
    MODE_SR       = 4'd11,
    MODE_SR_IND_Y = 4'd12
  } mode_t;

  typedef struct packed {
    mode_t      mode;
    logic [1:0] len;
  } class_t;

  // decoder state that does not depend on the offset width
  typedef struct packed {
    logic [1:0] rem;
    logic [7:0] held_op;
    logic [7:0] held_low;
    mode_t      held_mode;
    logic [1:0] held_len;
    logic       acc_narrow;
    logic       idx_narrow;
  } dec_state_t;

  typedef struct packed {
    logic        trunc;
    logic [15:0] operand;
    logic [1:0]  len;
    mode_t       mode;
    logic [7:0]  opcode;
    logic [15:0] addr;
  } result_t;

  function automatic class_t classify(input logic [7:0] op, input logic acc_n,
                                      input logic idx_n);
    class_t c;
    unique case (op)
      8'hA9, 8'h69, 8'hE9, 8'hC9: begin
        c.mode = MODE_IMM;
        c.len  = acc_n ? 2'd2 : 2'd3;
      end
      8'hA2, 8'hA0, 8'hE0, 8'hC0: begin
        c.mode = MODE_IMM;
        c.len  = idx_n ? 2'd2 : 2'd3;
      end
      OP_REP, OP_SEP: begin
        c.mode = MODE_IMM;
        c.len  = 2'd2;
      end
      8'h10, 8'h30, 8'h50, 8'h70, 8'h90, 8'hB0, 8'hD0, 8'hF0, 8'h80: begin
        c.mode = MODE_REL;
        c.len  = 2'd2;
      end
      8'h82: begin
        c.mode = MODE_REL_LONG;
        c.len  = 2'd3;
      end
      8'hA5, 8'h85, 8'hA6, 8'h65, 8'hE5: begin
        c.mode = MODE_DP;
        c.len  = 2'd2;
      end
      8'hB5, 8'h95, 8'h75, 8'hF5: begin
        c.mode = MODE_DP_X;
        c.len  = 2'd2;
      end
      8'hAD, 8'h8D, 8'h6D, 8'hED, 8'h20: begin
        c.mode = MODE_ABS;
        c.len  = 2'd3;
      end
      8'hBD, 8'h9D, 8'h7D, 8'hFD: begin
        c.mode = MODE_ABS_X;
        c.len  = 2'd3;
      end
      8'hB9, 8'h99, 8'h79, 8'hF9: begin
        c.mode = MODE_ABS_Y;
        c.len  = 2'd3;
      end
      8'hB2, 8'h92, 8'h72, 8'hF2: begin
        c.mode = MODE_DP_IND;
        c.len  = 2'd2;
      end
      8'hA7, 8'h87: begin
        c.mode = MODE_DP_LONG;
        c.len  = 2'd2;
      end
      8'hA3, 8'h83: begin
        c.mode = MODE_SR;
        c.len  = 2'd2;
      end
      8'hB3, 8'h93: begin
        c.mode = MODE_SR_IND_Y;
        c.len  = 2'd2;
      end
      default: begin
        c.mode = MODE_IMPLIED;
        c.len  = 2'd1;
      end
    endcase
    return c;
  endfunction

endpackage

/* hw/rtl/ibd_decode.sv */
// per-byte decode step: next decoder state, offsets and the finished instruction
`timescale 1ns / 1ps

module ibd_decode #(
  parameter int OFFSET_BITS = 16
) (
  input  ibd_pkg::dec_state_t     st,
  input  logic [OFFSET_BITS-1:0]  byte_offset,
  input  logic [OFFSET_BITS-1:0]  start_offset,
  input  logic [15:0]             origin,
  input  logic [7:0]              code_byte,
  input  logic                    last_byte,
  output ibd_pkg::dec_state_t     st_nxt,
  output logic [OFFSET_BITS-1:0]  byte_offset_nxt,
  output logic [OFFSET_BITS-1:0]  start_offset_nxt,
  output logic                    emit,
  output ibd_pkg::result_t        res
);
  import ibd_pkg::*;

  class_t                 cls;
  logic [OFFSET_BITS-1:0] start_cur;

  assign cls       = classify(code_byte, st.acc_narrow, st.idx_narrow);
  assign start_cur = (st.rem == 2'd0) ? byte_offset : start_offset;

  always_comb begin
    st_nxt           = st;
    start_offset_nxt = start_cur;
    emit             = 1'b0;
    res.addr         = origin + 16'(start_cur);
    res.opcode       = st.held_op;
    res.mode         = st.held_mode;
    res.len          = st.held_len;
    res.operand      = 16'd0;
    res.trunc        = 1'b0;

    if (st.rem == 2'd0) begin
      res.opcode = code_byte;
      res.mode   = cls.mode;
      res.len    = cls.len;
      if (cls.len == 2'd1) begin
        emit = 1'b1;
      end else begin
        st_nxt.held_op   = code_byte;
        st_nxt.held_mode = cls.mode;
        st_nxt.held_len  = cls.len;
        st_nxt.rem       = 2'(cls.len - 2'd1);
        if (last_byte) begin
          // section ended right after the opcode
          emit       = 1'b1;
          res.trunc  = 1'b1;
          st_nxt.rem = 2'd0;
        end
      end
    end else if (st.rem == 2'd2) begin
      st_nxt.held_low = code_byte;
      st_nxt.rem      = 2'd1;
      if (last_byte) begin
        emit        = 1'b1;
        res.trunc   = 1'b1;
        res.operand = {8'd0, code_byte};
        st_nxt.rem  = 2'd0;
      end
    end else begin
      emit        = 1'b1;
      res.operand = (st.held_len == 2'd3) ? {code_byte, st.held_low} : {8'd0, code_byte};
      st_nxt.rem  = 2'd0;
    end

    // width flags follow a finished rep/sep
    if (emit && res.opcode == OP_SEP) begin
      if (res.operand[MFLAG_BIT]) st_nxt.acc_narrow = 1'b1;
      if (res.operand[XFLAG_BIT]) st_nxt.idx_narrow = 1'b1;
    end else if (emit && res.opcode == OP_REP) begin
      if (res.operand[MFLAG_BIT]) st_nxt.acc_narrow = 1'b0;
      if (res.operand[XFLAG_BIT]) st_nxt.idx_narrow = 1'b0;
    end

    byte_offset_nxt = last_byte ? '0 : byte_offset + 1'b1;
  end

endmodule

/* hw/rtl/instr_boundary_decoder_mx_flags_top.sv */
// top level of the 65c816 instruction boundary decoder with m/x width tracking
`timescale 1ns / 1ps

// Takes one code byte per request and returns one request per complete
// instruction: address, opcode, addressing mode, length and operand. Each
// byte passes through the input register, then the decode table and byte
// counter into the result register, and a new byte is accepted every cycle
// while the result register is free or being drained. REP and SEP update the
// accumulator and index width flags as they complete. A section ending
// mid-instruction gives a result with the missing bytes as zero and the
// truncated flag set; the next byte starts a new section at code_origin.
// code_origin is written through cfg_wr_en/cfg_wr_data.
module instr_boundary_decoder_mx_flags_top #(
  parameter int OFFSET_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,    // code_origin
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,       // code_byte
  input  logic        in_tlast,       // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,      // instruction_address, opcode_byte, addressing_mode,
                                      // instruction_length, operand_value, zero pad
  output logic        out_tuser       // truncated
);
  import ibd_pkg::*;

  logic [15:0]            origin_r;
  logic                   s1_valid_r;
  logic [7:0]             s1_byte_r;
  logic                   s1_last_r;
  dec_state_t             st_r;
  dec_state_t             st_nxt;
  logic [OFFSET_BITS-1:0] byte_offset_r;
  logic [OFFSET_BITS-1:0] byte_offset_nxt;
  logic [OFFSET_BITS-1:0] start_offset_r;
  logic [OFFSET_BITS-1:0] start_offset_nxt;
  logic                   emit;
  result_t                res;
  logic                   out_valid_r;
  result_t                out_res_r;
  logic                   out_free;
  logic                   s1_adv;

  ibd_decode #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_decode (
    .st               (st_r),
    .byte_offset      (byte_offset_r),
    .start_offset     (start_offset_r),
    .origin           (origin_r),
    .code_byte        (s1_byte_r),
    .last_byte        (s1_last_r),
    .st_nxt           (st_nxt),
    .byte_offset_nxt  (byte_offset_nxt),
    .start_offset_nxt (start_offset_nxt),
    .emit             (emit),
    .res              (res)
  );

  assign out_free  = !out_valid_r || out_tready;
  // a byte that finishes nothing never waits on the output side
  assign s1_adv    = s1_valid_r && (!emit || out_free);
  assign in_tready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_r       <= ORIGIN_RESET;
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      st_r           <= '{rem: 2'd0, held_op: 8'd0, held_low: 8'd0, held_mode: MODE_IMPLIED,
                          held_len: 2'd1, acc_narrow: 1'b1, idx_narrow: 1'b1};
      byte_offset_r  <= '0;
      start_offset_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        origin_r <= cfg_wr_data;
      end
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (s1_adv) begin
        st_r           <= st_nxt;
        byte_offset_r  <= byte_offset_nxt;
        start_offset_r <= start_offset_nxt;
      end
      if (s1_adv && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
    if (s1_adv && emit) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_res_r.operand, out_res_r.len, out_res_r.mode,
                       out_res_r.opcode, out_res_r.addr};
  assign out_tuser  = out_res_r.trunc;

endmodule

/* tb/tb_instr_boundary_decoder_mx_flags_top.sv */
// self-checking testbench for the 65c816 instruction boundary decoder top level
`timescale 1ns / 1ps

module tb_instr_boundary_decoder_mx_flags_top;
  import ibd_pkg::*;

  localparam int SETTLE_CYCLES = 4;
  localparam int MAX_GAP       = 17;

  // {last, byte}: narrow and wide immediates across rep/sep, long branch,
  // section end on a complete instruction, then truncated abs, rep and brl
  localparam logic [8:0] DIRECTED_BYTES [30] = '{
    9'h0EA,
    9'h0A9, 9'h012,
    9'h0C2, 9'h030,
    9'h0A9, 9'h034, 9'h012,
    9'h0A2, 9'h0FF, 9'h0FF,
    9'h0E2, 9'h020,
    9'h0A9, 9'h080,
    9'h0A0, 9'h001, 9'h000,
    9'h082, 9'h000, 9'h080,
    9'h020, 9'h0CD, 9'h1AB,
    9'h0AD, 9'h134,
    9'h1C2,
    9'h0E2, 9'h030,
    9'h182
  };

  localparam logic [7:0] LISTED_OPS [52] = '{
    8'hA9, 8'h69, 8'hE9, 8'hC9, 8'hA2, 8'hA0, 8'hE0, 8'hC0, OP_REP, OP_SEP,
    8'h10, 8'h30, 8'h50, 8'h70, 8'h90, 8'hB0, 8'hD0, 8'hF0, 8'h80,
    8'h82,
    8'hA5, 8'h85, 8'hA6, 8'h65, 8'hE5,
    8'hB5, 8'h95, 8'h75, 8'hF5,
    8'hAD, 8'h8D, 8'h6D, 8'hED, 8'h20,
    8'hBD, 8'h9D, 8'h7D, 8'hFD,
    8'hB9, 8'h99, 8'h79, 8'hF9,
    8'hB2, 8'h92, 8'h72, 8'hF2,
    8'hA7, 8'h87,
    8'hA3, 8'h83,
    8'hB3, 8'h93
  };

  class boundary_predictor;
    logic [15:0] code_origin;
    logic [1:0]  rem;
    logic [7:0]  held_op;
    logic [7:0]  held_low;
    logic [15:0] offset;
    logic [15:0] start_offset;
    logic        acc_narrow;
    logic        idx_narrow;
    int          errors;
    result_t     expected_instrs[$];

    function new();
      code_origin  = ORIGIN_RESET;
      rem          = 2'd0;
      held_op      = 8'h00;
      held_low     = 8'h00;
      offset       = 16'h0000;
      start_offset = 16'h0000;
      acc_narrow   = 1'b1;
      idx_narrow   = 1'b1;
      errors       = 0;
    endfunction

    function void decode(input logic [7:0] op, output mode_t m, output logic [1:0] len);
      m   = MODE_IMM;
      len = 2'd2;
      case (op)
        8'hA9, 8'h69, 8'hE9, 8'hC9: len = acc_narrow ? 2'd2 : 2'd3;
        8'hA2, 8'hA0, 8'hE0, 8'hC0: len = idx_narrow ? 2'd2 : 2'd3;
        OP_REP, OP_SEP: ;
        8'h10, 8'h30, 8'h50, 8'h70, 8'h90, 8'hB0, 8'hD0, 8'hF0, 8'h80: m = MODE_REL;
        8'h82: begin
          m   = MODE_REL_LONG;
          len = 2'd3;
        end
        8'hA5, 8'h85, 8'hA6, 8'h65, 8'hE5: m = MODE_DP;
        8'hB5, 8'h95, 8'h75, 8'hF5: m = MODE_DP_X;
        8'hAD, 8'h8D, 8'h6D, 8'hED, 8'h20: begin
          m   = MODE_ABS;
          len = 2'd3;
        end
        8'hBD, 8'h9D, 8'h7D, 8'hFD: begin
          m   = MODE_ABS_X;
          len = 2'd3;
        end
        8'hB9, 8'h99, 8'h79, 8'hF9: begin
          m   = MODE_ABS_Y;
          len = 2'd3;
        end
        8'hB2, 8'h92, 8'h72, 8'hF2: m = MODE_DP_IND;
        8'hA7, 8'h87: m = MODE_DP_LONG;
        8'hA3, 8'h83: m = MODE_SR;
        8'hB3, 8'h93: m = MODE_SR_IND_Y;
        default: begin
          m   = MODE_IMPLIED;
          len = 2'd1;
        end
      endcase
    endfunction

    function int length_of(input logic [7:0] op);
      mode_t      m;
      logic [1:0] len;
      decode(op, m, len);
      return int'(len);
    endfunction

    function void emit_instr(input logic [7:0] op, input mode_t m, input logic [1:0] len,
                             input logic [15:0] val, input logic trunc);
      result_t r;
      r.addr    = code_origin + start_offset;
      r.opcode  = op;
      r.mode    = m;
      r.len     = len;
      r.operand = val;
      r.trunc   = trunc;
      expected_instrs.push_back(r);
      // width flags move only once the rep/sep itself is complete
      if (op == OP_SEP) begin
        if (val[MFLAG_BIT]) acc_narrow = 1'b1;
        if (val[XFLAG_BIT]) idx_narrow = 1'b1;
      end else if (op == OP_REP) begin
        if (val[MFLAG_BIT]) acc_narrow = 1'b0;
        if (val[XFLAG_BIT]) idx_narrow = 1'b0;
      end
    endfunction

    function void note_byte(input logic [7:0] b, input logic last);
      mode_t      m;
      logic [1:0] len;
      if (rem == 2'd0) begin
        start_offset = offset;
        decode(b, m, len);
        if (len == 2'd1) begin
          emit_instr(b, m, len, 16'h0000, 1'b0);
        end else begin
          held_op = b;
          rem     = len - 2'd1;
          if (last) begin
            emit_instr(b, m, len, 16'h0000, 1'b1);
            rem = 2'd0;
          end
        end
      end else begin
        decode(held_op, m, len);
        if (rem >= 2'd2) begin
          held_low = b;
          rem      = 2'd1;
          if (last) begin
            emit_instr(held_op, m, len, {8'h00, b}, 1'b1);
            rem = 2'd0;
          end
        end else begin
          emit_instr(held_op, m, len, (len == 2'd3) ? {b, held_low} : {8'h00, b}, 1'b0);
          rem = 2'd0;
        end
      end
      offset = last ? 16'h0000 : offset + 16'd1;
    endfunction

    function void check_instr(input logic [47:0] d, input logic trunc);
      result_t e;
      if (expected_instrs.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: unexpected result tdata %h tuser %b", $realtime, d, trunc);
        return;
      end
      e = expected_instrs.pop_front();
      if (d[15:0] != e.addr || d[23:16] != e.opcode || d[27:24] != 4'(e.mode) ||
          d[29:28] != e.len || d[45:30] != e.operand || trunc != e.trunc) begin
        errors++;
        if (errors <= 10) begin
          $display("%0t: mismatch exp addr %h op %h mode %0d len %0d val %h trunc %b",
                   $realtime, e.addr, e.opcode, e.mode, e.len, e.operand, e.trunc);
          $display("%0t:          got addr %h op %h mode %0d len %0d val %h trunc %b",
                   $realtime, d[15:0], d[23:16], d[27:24], d[29:28], d[45:30], trunc);
        end
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n       = 1'b0;
  logic        cfg_wr_en   = 1'b0;
  logic [15:0] cfg_wr_data = 16'h0000;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata    = 8'h00;
  logic        in_tlast    = 1'b0;
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [47:0] out_tdata;
  logic        out_tuser;

  logic in_idle_on  = 1'b1;
  logic out_idle_on = 1'b1;

  boundary_predictor pred = new();

  instr_boundary_decoder_mx_flags_top i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("Verification failed");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = in_idle_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    do @(posedge clk); while (in_tready !== 1'b1);
    pred.note_byte(b, last);
  endtask

  // sender holds off until every outstanding instruction has come back
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pred.expected_instrs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_code_origin(input logic [15:0] v);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    pred.code_origin = v;
  endtask

  // mostly well-formed instructions, some raw bytes, random section ends
  task automatic gen_stream(input int n, input int last_odds);
    int         sent;
    int         pick;
    int         nbytes;
    logic [7:0] op;
    logic       last;
    sent = 0;
    last = 1'b0;
    while (sent < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) op = $urandom_range(0, 1) ? OP_REP : OP_SEP;
      else if (pick < 85) op = LISTED_OPS[$urandom_range(0, 51)];
      else op = 8'($urandom_range(0, 255));
      nbytes = pred.length_of(op);
      last = 1'b0;
      for (int k = 0; k < nbytes; k++) begin
        if (!last) begin
          last = (last_odds != 0) && ($urandom_range(1, last_odds) == 1);
          send_byte((k == 0) ? op : 8'($urandom), last);
          sent++;
        end
      end
    end
    if (!last) send_byte(8'($urandom), 1'b1);
  endtask

  initial begin
    int stall;
    wait (rst_n === 1'b1);
    forever begin
      stall = out_idle_on ? $urandom_range(0, MAX_GAP) : 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
      pred.check_instr(out_tdata, out_tuser);
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED_BYTES[i]) send_byte(DIRECTED_BYTES[i][7:0], DIRECTED_BYTES[i][8]);

    set_code_origin(16'h0000);
    gen_stream(190, 25);
    set_code_origin(16'hFFFF);
    gen_stream(190, 25);

    // one long section run at full rate
    set_code_origin(16'($urandom));
    in_idle_on  = 1'b0;
    out_idle_on = 1'b0;
    gen_stream(150, 0);

    for (int p = 0; p < 3; p++) begin
      set_code_origin((p == 0) ? 16'hFFFE : 16'($urandom));
      in_idle_on  = ($urandom_range(0, 3) != 0);
      out_idle_on = ($urandom_range(0, 3) != 0);
      gen_stream(130, 25);
    end

    settle();
    if (pred.errors == 0 && pred.expected_instrs.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
